@@ hdl/stpq_pkg.sv @@
package stpq_pkg;

  // Request codes on the op field
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // One task record as held in a cell
  typedef struct packed {
    logic [15:0] req;
    logic [15:0] tok;
    logic [7:0]  expert;
    logic [7:0]  prio;
  } rec_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

@@ hdl/sorted_task_priority_queue_top.sv @@
// Sorted task priority queue.
//
// Input channel (in_valid / in_stall) carries one request: op selects push
// (record fields given) or pop. Output channel (out_valid / out_stall)
// returns one result per request: ok, the popped record (zeros for a push
// or a failed request) and the occupancy after the request.
//
// Records live in a row of DEPTH cells, cell 0 on top holding the largest
// expert number. Every cell compares its key with the pushed key at once
// and either holds, takes the new record or takes its upper neighbor; a pop
// shifts every cell up by one. Among equal keys the newest sits on top.
//
// out_valid rises in the cycle after acceptance; one request is taken
// every cycle while in_stall is low, set by the single cell update of the
// chain. A result waits in the output register while out_stall is high,
// and in_stall is raised only while that register is full and stalled.
// A push when full is dropped with ok low; a pop when empty gives ok low.
// Reset empties the queue at once and clears out_valid; cell contents are
// left as they are, since the count alone marks which cells are held.
module sorted_task_priority_queue_top
  import stpq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [15:0] request_num,
  input  logic [15:0] token_num,
  input  logic [7:0]  expert_num,
  input  logic [7:0]  task_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [15:0] out_request,
  output logic [15:0] out_token,
  output logic [7:0]  out_expert,
  output logic [7:0]  out_priority,
  output logic [7:0]  occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count, count_next;
  logic          accept, full, empty;
  cell_ctrl_t    ctrl;
  rec_t          new_rec;
  rec_t          cell_rec [DEPTH];
  logic [DEPTH:0] keep;  // keep[i+1] belongs to cell i; keep[0] is the top sentinel

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  assign ctrl.push = accept && (op == OP_PUSH) && !full;
  assign ctrl.pop  = accept && (op == OP_POP) && !empty;

  assign new_rec.req    = request_num;
  assign new_rec.tok    = token_num;
  assign new_rec.expert = expert_num;
  assign new_rec.prio   = task_priority;

  assign keep[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t next_rec;
    if (i == DEPTH - 1) begin : g_last
      assign next_rec = '0;
    end else begin : g_mid
      assign next_rec = cell_rec[i+1];
    end

    stpq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_rec  (new_rec),
      .occupied (CW'(i) < count),
      .prev_keep(keep[i]),
      .prev_rec ((i == 0) ? new_rec : cell_rec[(i == 0) ? 0 : i-1]),
      .next_rec (next_rec),
      .rec      (cell_rec[i]),
      .keep     (keep[i+1])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok           <= ctrl.push || ctrl.pop;
      out_request  <= ctrl.pop ? cell_rec[0].req    : 16'd0;
      out_token    <= ctrl.pop ? cell_rec[0].tok    : 16'd0;
      out_expert   <= ctrl.pop ? cell_rec[0].expert : 8'd0;
      out_priority <= ctrl.pop ? cell_rec[0].prio   : 8'd0;
      occupancy    <= 8'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> count == $past(count) + CW'(1))
    else $error("push did not grow count");

  a_top_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> cell_rec[0].expert >= cell_rec[1].expert)
    else $error("top cells out of order");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> out_valid && ok && out_expert == $past(cell_rec[0].expert))
    else $error("pop result mismatch");

endmodule

@@ hdl/stpq_cell.sv @@
module stpq_cell
  import stpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  rec_t       new_rec,
  input  logic       occupied,
  input  logic       prev_keep,
  input  rec_t       prev_rec,
  input  rec_t       next_rec,
  output rec_t       rec,
  output logic       keep
);

  // A held record with a strictly larger key stays put on a push
  assign keep = occupied && (rec.expert > new_rec.expert);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (!keep) begin
        rec <= prev_keep ? new_rec : prev_rec;
      end
    end else if (ctrl.pop) begin
      rec <= next_rec;
    end
  end

endmodule

@@ test/sorted_task_priority_queue_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, keeps a sorted copy of the queue and compares
// every result with the oldest prediction.
module sorted_task_priority_queue_checker
  import stpq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        op,
  input  logic [15:0] request_num,
  input  logic [15:0] token_num,
  input  logic [7:0]  expert_num,
  input  logic [7:0]  task_priority,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        ok,
  input  logic [15:0] out_request,
  input  logic [15:0] out_token,
  input  logic [7:0]  out_expert,
  input  logic [7:0]  out_priority,
  input  logic [7:0]  occupancy,
  output int          pending,
  output int          errors
);

  typedef struct packed {
    logic        ok;
    logic [15:0] req;
    logic [15:0] tok;
    logic [7:0]  expert;
    logic [7:0]  prio;
    logic [7:0]  occ;
  } queue_result_t;

  // cells[0] holds the smallest key, cells[held - 1] the top
  rec_t          cells[DEPTH];
  int            held;
  queue_result_t expected_results[$];

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : track
    queue_result_t want;
    queue_result_t fresh;
    rec_t          rec;
    int            pos;
    if (rst) begin
      held   = 0;
      errors = 0;
      expected_results.delete();
    end else begin
      // result leaving first: it belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result with nothing pending", int'(ok), 0);
        end else begin
          want = expected_results.pop_front();
          if (ok !== want.ok) report("ok", int'(ok), int'(want.ok));
          if (out_request !== want.req)
            report("out_request", int'(out_request), int'(want.req));
          if (out_token !== want.tok)
            report("out_token", int'(out_token), int'(want.tok));
          if (out_expert !== want.expert)
            report("out_expert", int'(out_expert), int'(want.expert));
          if (out_priority !== want.prio)
            report("out_priority", int'(out_priority), int'(want.prio));
          if (occupancy !== want.occ)
            report("occupancy", int'(occupancy), int'(want.occ));
        end
      end
      if (in_valid && !in_stall) begin
        fresh = '0;
        if (op == OP_PUSH) begin
          if (held < DEPTH) begin
            rec.req    = request_num;
            rec.tok    = token_num;
            rec.expert = expert_num;
            rec.prio   = task_priority;
            // larger keys move up; equal keys stay below the new one
            pos = held;
            while (pos > 0 && cells[pos - 1].expert > rec.expert) begin
              cells[pos] = cells[pos - 1];
              pos--;
            end
            cells[pos] = rec;
            held++;
            fresh.ok = 1'b1;
          end
        end else if (held > 0) begin
          rec          = cells[held - 1];
          held--;
          fresh.ok     = 1'b1;
          fresh.req    = rec.req;
          fresh.tok    = rec.tok;
          fresh.expert = rec.expert;
          fresh.prio   = rec.prio;
        end
        fresh.occ = 8'(held);
        expected_results.insert(expected_results.size(), fresh);
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ test/tb_sorted_task_priority_queue_top.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted task priority queue. The checker
// instance does all prediction and comparison; this module only drives
// requests, stalls the result side and decides pass/fail.
module tb_sorted_task_priority_queue_top;
  import stpq_pkg::*;

  localparam int DEPTH          = 128;
  // Longest idle stretch: a receiver stall plus a sender gap; the limit
  // takes that stretch many times over.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [15:0] request_num;
  logic [15:0] token_num;
  logic [7:0]  expert_num;
  logic [7:0]  task_priority;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [15:0] out_request;
  logic [15:0] out_token;
  logic [7:0]  out_expert;
  logic [7:0]  out_priority;
  logic [7:0]  occupancy;

  int pending;
  int errors;
  int burst_left;
  int idle_cycles;

  sorted_task_priority_queue_top #(.DEPTH(DEPTH)) dut (.*);

  sorted_task_priority_queue_checker #(.DEPTH(DEPTH)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side back-pressure, independent of the sender. Modes:
  // free-running, random coin flips, one long hold, and strict toggling.
  initial begin : receiver_stalls
    int mode;
    int span;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      case (mode)
        0: begin
          out_stall <= 1'b0;
          repeat (span) @(negedge clk);
        end
        1: begin
          repeat (span) begin
            out_stall <= 1'($urandom_range(0, 1));
            @(negedge clk);
          end
        end
        2: begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        default: begin
          repeat (span) begin
            out_stall <= ~out_stall;
            @(negedge clk);
          end
        end
      endcase
    end
  end

  // Drives one request at a falling edge and holds it until the block
  // takes it. Bursts of random length are separated by random gaps; a gap
  // of zero keeps valid high across bursts. Returns at a falling edge.
  task automatic send_request(input logic kind, input logic [15:0] rq,
                              input logic [15:0] tk, input logic [7:0] ex,
                              input logic [7:0] pr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    op            <= kind;
    request_num   <= rq;
    token_num     <= tk;
    expert_num    <= ex;
    task_priority <= pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request with random content. Half the keys come from a tiny
  // range so that equal expert numbers pile up; the extremes show up often.
  task automatic send_random(input int push_pct);
    int          pick;
    logic [7:0]  key;
    pick = $urandom_range(0, 9);
    if (pick < 5)       key = 8'($urandom_range(0, 7));
    else if (pick == 5) key = 8'h00;
    else if (pick == 6) key = 8'hff;
    else                key = 8'($urandom_range(0, 255));
    send_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                 16'($urandom), 16'($urandom), key, 8'($urandom));
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    op            <= OP_PUSH;
    request_num   <= '0;
    token_num     <= '0;
    expert_num    <= '0;
    task_priority <= '0;
    burst_left    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pop on empty, field extremes, ties in the middle and at
    // the top, drain in expected order, then pop on empty again.
    send_request(OP_POP,  16'h0000, 16'h0000, 8'h00, 8'h00);
    send_request(OP_PUSH, 16'hffff, 16'hffff, 8'h00, 8'hff);
    send_request(OP_PUSH, 16'h0000, 16'h0000, 8'hff, 8'h00);
    send_request(OP_PUSH, 16'h1111, 16'h0001, 8'h05, 8'h10);
    send_request(OP_PUSH, 16'h2222, 16'h0002, 8'h05, 8'h20);
    send_request(OP_PUSH, 16'h3333, 16'h0003, 8'hff, 8'h30);
    send_request(OP_PUSH, 16'ha5a5, 16'h5a5a, 8'h80, 8'h81);
    repeat (6) send_request(OP_POP, 16'hffff, 16'hffff, 8'hff, 8'hff);
    send_request(OP_POP, 16'h0000, 16'h0000, 8'h00, 8'h00);
    wait_drained();

    // Random: fill past full so pushes get dropped, hold off until idle,
    // drain past empty, then a balanced mix.
    repeat (200) send_random(95);
    wait_drained();
    repeat (200) send_random(5);
    repeat (200) send_random(50);

    wait_drained();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/stpq_pkg.sv
hdl/stpq_cell.sv
hdl/sorted_task_priority_queue_top.sv
test/sorted_task_priority_queue_checker.sv
test/tb_sorted_task_priority_queue_top.sv
